// ===== hw/rtl/flc_pkg.sv =====
// shared types and constants for the forest link/cut lca block
package flc_pkg;

  localparam int unsigned NODE_W        = 8;
  localparam int unsigned TABLE_DEPTH   = 256;
  localparam int unsigned ACTION_W      = 2;
  localparam int unsigned NODES_DEFAULT = 256;

  typedef enum logic [ACTION_W-1:0] {
    ACT_LINK  = 2'd0,
    ACT_CUT   = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef logic [NODE_W-1:0] node_t;

  // write request into the parent table
  typedef struct packed {
    logic  link;
    logic  cut;
    node_t node;
    node_t parent;
  } tbl_wr_t;

endpackage

// ===== hw/rtl/flc_if.sv =====
// handshake channels: request items in, query results out
interface flc_in_if;
  logic                            valid;
  logic                            ready;
  logic [flc_pkg::ACTION_W-1:0]    action;
  logic [flc_pkg::NODE_W-1:0]      node_a;
  logic [flc_pkg::NODE_W-1:0]      node_b;

  modport source (output valid, output action, output node_a, output node_b, input ready);
  modport sink   (input valid, input action, input node_a, input node_b, output ready);
endinterface

interface flc_out_if;
  logic                            valid;
  logic                            ready;
  logic [flc_pkg::NODE_W-1:0]      ancestor;
  logic                            found;
  logic                            cycle_detected;

  modport source (output valid, output ancestor, output found, output cycle_detected,
                  input ready);
  modport sink   (input valid, input ancestor, input found, input cycle_detected,
                  output ready);
endinterface

// ===== hw/rtl/flc_parent_tbl.sv =====
// parent pointer table: ram of has-parent flag and parent per vertex, registered read
module flc_parent_tbl (
  input  logic             clk_i,
  input  flc_pkg::tbl_wr_t wr_i,
  input  flc_pkg::node_t   rd_addr_i,
  output flc_pkg::node_t   rd_parent_o,
  output logic             rd_valid_o
);

  typedef struct packed {
    logic           valid;
    flc_pkg::node_t parent;
  } entry_t;

  entry_t mem_q [flc_pkg::TABLE_DEPTH];
  entry_t rd_q;
  entry_t wr_ent;

  // a cut stores a root entry
  assign wr_ent.valid  = wr_i.link;
  assign wr_ent.parent = wr_i.link ? wr_i.parent : '0;

  always_ff @(posedge clk_i) begin
    if (wr_i.link || wr_i.cut) begin
      mem_q[wr_i.node] <= wr_ent;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_parent_o = rd_q.parent;
  assign rd_valid_o  = rd_q.valid;

endmodule

// ===== hw/rtl/forest_link_cut_lca.sv =====
// top level: parent-pointer forest with link, cut and lowest common ancestor query
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  req_i    | in  | valid / ready | action, node_a, node_b
//  rsp_o    | out | valid / ready | ancestor, found, cycle_detected
//
// link and cut items give no result item
// a query first walks from node_a up toward its root, then from node_b to the first marked vertex;
//   one vertex per cycle through the single parent-table read port
// reset starts a clearing pass over the parent table and the mark store,
//   ready stays low meanwhile
// marks carry a query number, so a query clears nothing; after every 255th in-range
//   query the mark store gets a clearing pass before the next item
// ready is low while a query walks; a finished result waits in the output
//   register and the next item is taken meanwhile, a later query holds in its
//   final state until the output register frees up
module forest_link_cut_lca #(
  parameter int unsigned NODES = flc_pkg::NODES_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  flc_in_if.sink    req_i,
  flc_out_if.source rsp_o
);

  // step counter covers 0 .. NODES-1
  localparam int unsigned STEP_W = (NODES > 2) ? $clog2(NODES) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NODES - 1);
  localparam logic [16:0] NODES_L = 17'(NODES);
  localparam int unsigned EPOCH_W = 8;

  typedef logic [EPOCH_W-1:0] epoch_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_SEEK,
    ST_DONE
  } state_e;

  state_e                          state_q, state_d;
  flc_pkg::node_t                  v_q, v_d;       // vertex under the walk
  flc_pkg::node_t                  b_q, b_d;       // start of the second walk
  logic [STEP_W-1:0]               steps_q, steps_d;
  logic                            cyc_q, cyc_d;
  logic                            fnd_q, fnd_d;
  epoch_t                          epoch_q, epoch_d;   // number of the current query
  flc_pkg::node_t                  clr_q, clr_d;       // clearing pass address
  logic                            clr_tbl_q, clr_tbl_d;
  logic                            ov_q, ov_d;
  flc_pkg::node_t                  oanc_q, oanc_d;
  logic                            ofnd_q, ofnd_d;
  logic                            ocyc_q, ocyc_d;

  // mark store: a vertex is marked when it holds the current query number
  epoch_t                          mark_mem [flc_pkg::TABLE_DEPTH];
  epoch_t                          mark_rd_q;
  logic                            mk_we;
  flc_pkg::node_t                  mk_waddr;
  epoch_t                          mk_wdata;
  logic                            marked;

  flc_pkg::tbl_wr_t wr;
  flc_pkg::node_t   parent;
  logic             has_parent;
  logic             accept;
  logic             out_free;
  logic             a_ok, b_ok;
  logic             at_last;

  flc_parent_tbl u_tbl (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .rd_addr_i   (v_d),       // read next vertex so its parent is ready in the following cycle
    .rd_parent_o (parent),
    .rd_valid_o  (has_parent)
  );

  // same read timing as the parent table; a write to the read address passes through
  always_ff @(posedge clk_i) begin
    if (mk_we) begin
      mark_mem[mk_waddr] <= mk_wdata;
    end
    if (mk_we && (mk_waddr == v_d)) begin
      mark_rd_q <= mk_wdata;
    end else begin
      mark_rd_q <= mark_mem[v_d];
    end
  end

  assign marked      = (mark_rd_q == epoch_q);
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !ov_q || rsp_o.ready;
  // vertex index must lie below NODES
  assign a_ok        = {9'd0, req_i.node_a} < NODES_L;
  assign b_ok        = {9'd0, req_i.node_b} < NODES_L;
  assign at_last     = (steps_q == STEP_LAST);

  always_comb begin
    state_d   = state_q;
    v_d       = v_q;
    b_d       = b_q;
    steps_d   = steps_q;
    cyc_d     = cyc_q;
    fnd_d     = fnd_q;
    epoch_d   = epoch_q;
    clr_d     = clr_q;
    clr_tbl_d = clr_tbl_q;
    ov_d      = ov_q;
    oanc_d    = oanc_q;
    ofnd_d    = ofnd_q;
    ocyc_d    = ocyc_q;
    wr        = '0;
    mk_we     = 1'b0;
    mk_waddr  = v_q;
    mk_wdata  = epoch_q;

    // result taken downstream
    if (ov_q && rsp_o.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      // clear the mark store, and the parent table after reset
      ST_CLEAR: begin
        mk_we    = 1'b1;
        mk_waddr = clr_q;
        mk_wdata = '0;
        wr.cut   = clr_tbl_q;
        wr.node  = clr_q;
        if (clr_q == '1) begin
          clr_tbl_d = 1'b0;
          epoch_d   = '0;
          state_d   = ST_IDLE;
        end else begin
          clr_d = clr_q + flc_pkg::node_t'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          wr.node   = req_i.node_a;
          wr.parent = req_i.node_b;
          case (flc_pkg::action_e'(req_i.action))
            flc_pkg::ACT_LINK: begin
              wr.link = a_ok && b_ok;
            end
            flc_pkg::ACT_CUT: begin
              wr.cut = a_ok;
            end
            flc_pkg::ACT_QUERY: begin
              cyc_d   = 1'b0;
              fnd_d   = 1'b0;
              steps_d = '0;
              v_d     = req_i.node_a;
              b_d     = req_i.node_b;
              if (a_ok && b_ok) begin
                epoch_d = epoch_q + epoch_t'(1);
                state_d = ST_MARK;
              end else begin
                // out-of-range query gives an all-zero result
                state_d = ST_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // mark node_a and each ancestor
      ST_MARK: begin
        mk_we    = 1'b1;
        mk_waddr = v_q;
        mk_wdata = epoch_q;
        if (!has_parent || at_last) begin
          cyc_d   = has_parent;
          steps_d = '0;
          v_d     = b_q;
          state_d = ST_SEEK;
        end else begin
          v_d     = parent;
          steps_d = steps_q + STEP_W'(1);
        end
      end

      // climb from node_b to the first marked vertex
      ST_SEEK: begin
        if (marked) begin
          fnd_d   = 1'b1;
          state_d = ST_DONE;
        end else if (!has_parent) begin
          state_d = ST_DONE;
        end else if (at_last) begin
          cyc_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          v_d     = parent;
          steps_d = steps_q + STEP_W'(1);
        end
      end

      ST_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          oanc_d  = fnd_q ? v_q : '0;
          ofnd_d  = fnd_q;
          ocyc_d  = cyc_q;
          // query numbers used up: wipe the marks before the next item
          if (epoch_q == '1) begin
            clr_d   = '0;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      v_q       <= '0;
      b_q       <= '0;
      steps_q   <= '0;
      cyc_q     <= 1'b0;
      fnd_q     <= 1'b0;
      epoch_q   <= '0;
      clr_q     <= '0;
      clr_tbl_q <= 1'b1;
      ov_q      <= 1'b0;
      oanc_q    <= '0;
      ofnd_q    <= 1'b0;
      ocyc_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      v_q       <= v_d;
      b_q       <= b_d;
      steps_q   <= steps_d;
      cyc_q     <= cyc_d;
      fnd_q     <= fnd_d;
      epoch_q   <= epoch_d;
      clr_q     <= clr_d;
      clr_tbl_q <= clr_tbl_d;
      ov_q      <= ov_d;
      oanc_q    <= oanc_d;
      ofnd_q    <= ofnd_d;
      ocyc_q    <= ocyc_d;
    end
  end

  assign rsp_o.valid          = ov_q;
  assign rsp_o.ancestor       = oanc_q;
  assign rsp_o.found          = ofnd_q;
  assign rsp_o.cycle_detected = ocyc_q;

`ifndef SYNTHESIS
  // walks always run under a fresh nonzero query number
  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK || state_q == ST_SEEK) |-> epoch_q != '0)
    else $error("walk under a cleared query number");

  // no item is taken during a clearing pass
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !req_i.ready)
    else $error("ready high during clearing pass");

  // a new result only comes out of the final state
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == ST_DONE)
    else $error("result raised outside final state");

  // a not-found result carries a zero vertex
  a_zero_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !ofnd_q) |-> oanc_q == '0)
    else $error("ancestor nonzero without found");

  // no item is taken while a query walks
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK || state_q == ST_SEEK) |=> !$past(accept))
    else $error("item accepted during walk");
`endif

endmodule
